// ----- design/assert_macros.svh -----
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high
`define DTBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define DTBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/dtbp_pkg.sv -----
package dtbp_pkg;

   typedef enum logic [8:0] {
      PH_HEADER     = 9'b000000001,
      PH_GAP_RSV    = 9'b000000010,
      PH_RSV        = 9'b000000100,
      PH_GAP_STRUCT = 9'b000001000,
      PH_TOKEN      = 9'b000010000,
      PH_NAME       = 9'b000100000,
      PH_PROP       = 9'b001000000,
      PH_SKIP       = 9'b010000000,
      PH_DONE       = 9'b100000000
   } phase_type;

   localparam logic [3:0] KIND_RESERVE   = 4'd0;
   localparam logic [3:0] KIND_NODE_BEG  = 4'd1;
   localparam logic [3:0] KIND_NAME_CHAR = 4'd2;
   localparam logic [3:0] KIND_NODE_END  = 4'd3;
   localparam logic [3:0] KIND_PROPERTY  = 4'd4;
   localparam logic [3:0] KIND_NOP       = 4'd5;
   localparam logic [3:0] KIND_END       = 4'd6;
   localparam logic [3:0] KIND_BAD_MAGIC = 4'd7;
   localparam logic [3:0] KIND_UNKNOWN   = 4'd8;

   localparam logic [31:0] FDT_MAGIC    = 32'hd00dfeed;
   localparam logic [31:0] TOK_BEGIN    = 32'h00000001;
   localparam logic [31:0] TOK_END_NODE = 32'h00000002;
   localparam logic [31:0] TOK_PROP     = 32'h00000003;
   localparam logic [31:0] TOK_NOP      = 32'h00000004;
   localparam logic [31:0] TOK_END      = 32'h00000009;

   // Header byte positions of the last byte of each field used
   localparam logic [31:0] HDR_MAGIC_LAST  = 32'd3;
   localparam logic [31:0] HDR_STRUCT_LAST = 32'd11;
   localparam logic [31:0] HDR_RSV_LAST    = 32'd19;
   localparam logic [31:0] HDR_LAST        = 32'd39;

endpackage

// ----- design/dtbp_if.sv -----
interface dtbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface dtbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [7:0]  depth;
   logic [63:0] reserve_address;
   logic [63:0] reserve_size;
   logic [31:0] property_length;
   logic [31:0] property_name_offset;
   logic [7:0]  name_char;
   logic [15:0] event_offset;

   modport source (output valid, output kind, output depth, output reserve_address,
                   output reserve_size, output property_length,
                   output property_name_offset, output name_char,
                   output event_offset, input ready);
   modport sink   (input valid, input kind, input depth, input reserve_address,
                   input reserve_size, input property_length,
                   input property_name_offset, input name_char,
                   input event_offset, output ready);
endinterface

// ----- design/device_tree_blob_parser_unit.sv -----
// Flattened device tree blob parser.
// req_ch carries the blob one byte per request; first_byte marks offset zero and
// restarts the parser from the header. rsp_ch carries at most one event per byte:
// reservation entries, node begin, name characters, node end, property, nop, end,
// bad magic and unknown token, each with its nesting depth and blob offset.
// Each request is registered in the input register, then parsed into the result
// register that drives rsp_ch. Throughput is one byte per cycle while rsp_ch does
// not stall, set by the update of the parse state (phase, shift word, counters);
// a new request is taken while a result waits.
// When rsp_ch stalls, the result register holds and the input register takes one
// more request; further requests wait until the result is taken.
// After end, unknown token or bad magic, and for bytes at offset BLOB_BYTES and
// beyond, bytes are consumed without events until the next first_byte.
// Synchronous reset empties both registers and returns the parser to the header
// phase at offset zero; no first_byte is needed after reset.
`include "assert_macros.svh"

module device_tree_blob_parser_unit import dtbp_pkg::*; #(
   parameter int BLOB_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   dtbp_req_if.sink    req_ch,
   dtbp_rsp_if.source  rsp_ch
);

   localparam int POS_W = $clog2(BLOB_BYTES + 1);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;

   // parse state
   logic [POS_W-1:0] pos_ff, pos_in;
   phase_type        phase_ff, phase_in;
   logic [63:0]      shift_ff, shift_in;
   logic [63:0]      held_addr_ff, held_addr_in;
   logic [31:0]      rsv_off_ff, rsv_off_in;
   logic [31:0]      struct_off_ff, struct_off_in;
   logic [31:0]      skip_ff, skip_in;
   logic [27:0]      held_len_ff, held_len_in;
   logic [7:0]       level_ff, level_in;
   logic [3:0]       field_ff, field_in;

   // result register
   logic        out_valid_ff;
   logic [3:0]  out_kind_ff;
   logic [7:0]  out_depth_ff;
   logic [63:0] out_addr_ff;
   logic [63:0] out_size_ff;
   logic [31:0] out_len_ff;
   logic [31:0] out_noff_ff;
   logic [7:0]  out_char_ff;
   logic [15:0] out_off_ff;

   logic adv, req_take;

   // working values
   logic [POS_W-1:0] cur_pos, nxt_pos;
   phase_type        cur_phase;
   logic [7:0]       cur_level;
   logic [3:0]       cur_field;
   logic [31:0]      p32, next32, low;
   logic [15:0]      p16;
   logic [63:0]      shift_new;
   logic [31:0]      struct_gap, rsv_gap, rsv_span;
   logic             struct_ahead, rsv_ahead;
   logic [27:0]      rsv_count;
   logic [31:0]      prop_len;
   logic [1:0]       prop_pad, name_pad;
   logic [33:0]      prop_skip;
   logic [31:0]      prop_skip_sat;

   logic        emit;
   logic [3:0]  e_kind;
   logic [63:0] e_addr, e_size;
   logic [31:0] e_len, e_noff;
   logic [7:0]  e_char;
   logic [15:0] e_off;

   assign adv      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_valid_ff || adv;

   assign rsp_ch.valid                = out_valid_ff;
   assign rsp_ch.kind                 = out_kind_ff;
   assign rsp_ch.depth                = out_depth_ff;
   assign rsp_ch.reserve_address      = out_addr_ff;
   assign rsp_ch.reserve_size         = out_size_ff;
   assign rsp_ch.property_length      = out_len_ff;
   assign rsp_ch.property_name_offset = out_noff_ff;
   assign rsp_ch.name_char            = out_char_ff;
   assign rsp_ch.event_offset         = out_off_ff;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // restart replaces the control state before the byte is parsed
   always_comb begin
      cur_pos   = in_first_ff ? '0 : pos_ff;
      cur_phase = in_first_ff ? PH_HEADER : phase_ff;
      cur_level = in_first_ff ? 8'd0 : level_ff;
      cur_field = in_first_ff ? 4'd0 : field_ff;
   end

   assign nxt_pos   = cur_pos + POS_W'(1);
   assign p32       = 32'(cur_pos);
   assign next32    = 32'(nxt_pos);
   assign p16       = 16'(cur_pos);
   assign shift_new = {shift_ff[55:0], in_byte_ff};
   assign low       = shift_new[31:0];

   assign struct_ahead = struct_off_ff > next32;
   assign struct_gap   = struct_off_ff - next32;
   assign rsv_ahead    = rsv_off_ff > next32;
   assign rsv_gap      = rsv_off_ff - next32;
   assign rsv_span     = struct_off_ff - rsv_off_ff;
   assign rsv_count    = (struct_off_ff > rsv_off_ff) ? rsv_span[31:4] : 28'd0;

   // value plus padding up to the next 4-byte boundary
   assign prop_len      = shift_new[63:32];
   assign prop_pad      = 2'd0 - (next32[1:0] + prop_len[1:0]);
   assign prop_skip     = {2'b00, prop_len} + {32'd0, prop_pad};
   assign prop_skip_sat = (prop_skip[33:32] != 2'b00) ? 32'hffffffff : prop_skip[31:0];
   assign name_pad      = 2'd0 - next32[1:0];

   always_comb begin
      pos_in        = cur_pos;
      phase_in      = cur_phase;
      shift_in      = shift_ff;
      held_addr_in  = held_addr_ff;
      rsv_off_in    = rsv_off_ff;
      struct_off_in = struct_off_ff;
      skip_in       = skip_ff;
      held_len_in   = held_len_ff;
      level_in      = cur_level;
      field_in      = cur_field;
      emit          = 1'b0;
      e_kind        = KIND_NOP;
      e_addr        = 64'd0;
      e_size        = 64'd0;
      e_len         = 32'd0;
      e_noff        = 32'd0;
      e_char        = 8'd0;
      e_off         = p16 - 16'd3;

      if (32'(cur_pos) >= 32'(BLOB_BYTES)) begin
         phase_in = PH_DONE;
      end else begin
         pos_in   = nxt_pos;
         shift_in = shift_new;
         case (cur_phase)
            PH_HEADER: begin
               if (p32 == HDR_MAGIC_LAST && low != FDT_MAGIC) begin
                  phase_in = PH_DONE;
                  emit     = 1'b1;
                  e_kind   = KIND_BAD_MAGIC;
                  e_off    = 16'd0;
               end else begin
                  if (p32 == HDR_STRUCT_LAST) begin
                     struct_off_in = low;
                  end
                  if (p32 == HDR_RSV_LAST) begin
                     rsv_off_in = low;
                  end
                  if (p32 == HDR_LAST) begin
                     held_len_in = rsv_count;
                     field_in    = 4'd0;
                     if (rsv_count == 28'd0) begin
                        if (struct_ahead) begin
                           skip_in  = struct_gap;
                           phase_in = PH_GAP_STRUCT;
                        end else begin
                           phase_in = PH_TOKEN;
                        end
                     end else if (rsv_ahead) begin
                        skip_in  = rsv_gap;
                        phase_in = PH_GAP_RSV;
                     end else begin
                        phase_in = PH_RSV;
                     end
                  end
               end
            end
            PH_GAP_RSV: begin
               skip_in = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  phase_in = PH_RSV;
                  field_in = 4'd0;
               end
            end
            PH_RSV: begin
               field_in = cur_field + 4'd1;
               if (cur_field == 4'd7) begin
                  held_addr_in = shift_new;
               end
               if (cur_field == 4'd15) begin
                  emit        = 1'b1;
                  e_kind      = KIND_RESERVE;
                  e_off       = p16 - 16'd15;
                  e_addr      = held_addr_ff;
                  e_size      = shift_new;
                  field_in    = 4'd0;
                  held_len_in = held_len_ff - 28'd1;
                  if (held_len_ff == 28'd1) begin
                     if (struct_ahead) begin
                        skip_in  = struct_gap;
                        phase_in = PH_GAP_STRUCT;
                     end else begin
                        phase_in = PH_TOKEN;
                     end
                  end
               end
            end
            PH_GAP_STRUCT, PH_SKIP: begin
               skip_in = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  phase_in = PH_TOKEN;
                  field_in = 4'd0;
               end
            end
            PH_TOKEN: begin
               field_in = cur_field + 4'd1;
               if (cur_field == 4'd3) begin
                  field_in = 4'd0;
                  case (low)
                     TOK_BEGIN: begin
                        if (cur_level != 8'd255) begin
                           level_in = cur_level + 8'd1;
                        end
                        phase_in = PH_NAME;
                        emit     = 1'b1;
                        e_kind   = KIND_NODE_BEG;
                     end
                     TOK_END_NODE: begin
                        if (cur_level != 8'd0) begin
                           level_in = cur_level - 8'd1;
                        end
                        emit   = 1'b1;
                        e_kind = KIND_NODE_END;
                     end
                     TOK_PROP: begin
                        phase_in = PH_PROP;
                     end
                     TOK_NOP: begin
                        emit   = 1'b1;
                        e_kind = KIND_NOP;
                     end
                     TOK_END: begin
                        phase_in = PH_DONE;
                        emit     = 1'b1;
                        e_kind   = KIND_END;
                     end
                     default: begin
                        phase_in = PH_DONE;
                        emit     = 1'b1;
                        e_kind   = KIND_UNKNOWN;
                     end
                  endcase
               end
            end
            PH_NAME: begin
               if (in_byte_ff == 8'd0) begin
                  // terminator: skip padding to the next word
                  field_in = 4'd0;
                  if (name_pad != 2'd0) begin
                     skip_in  = 32'(name_pad);
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_TOKEN;
                  end
               end else begin
                  emit   = 1'b1;
                  e_kind = KIND_NAME_CHAR;
                  e_off  = p16;
                  e_char = in_byte_ff;
               end
            end
            PH_PROP: begin
               field_in = cur_field + 4'd1;
               if (cur_field == 4'd7) begin
                  held_len_in = prop_len[27:0];
                  emit        = 1'b1;
                  e_kind      = KIND_PROPERTY;
                  e_off       = p16 - 16'd11;
                  e_len       = prop_len;
                  e_noff      = low;
                  field_in    = 4'd0;
                  if (prop_skip_sat != 32'd0) begin
                     skip_in  = prop_skip_sat;
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_TOKEN;
                  end
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         phase_ff     <= PH_HEADER;
         level_ff     <= 8'd0;
         field_ff     <= 4'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (adv) begin
            out_valid_ff <= emit;
            pos_ff       <= pos_in;
            phase_ff     <= phase_in;
            level_ff     <= level_in;
            field_ff     <= field_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_ch.data_byte;
         in_first_ff <= req_ch.first_byte;
      end
      if (adv) begin
         shift_ff      <= shift_in;
         held_addr_ff  <= held_addr_in;
         rsv_off_ff    <= rsv_off_in;
         struct_off_ff <= struct_off_in;
         skip_ff       <= skip_in;
         held_len_ff   <= held_len_in;
         if (emit) begin
            out_kind_ff  <= e_kind;
            out_depth_ff <= level_in;
            out_addr_ff  <= e_addr;
            out_size_ff  <= e_size;
            out_len_ff   <= e_len;
            out_noff_ff  <= e_noff;
            out_char_ff  <= e_char;
            out_off_ff   <= e_off;
         end
      end
   end

   `DTBP_ASSERT(a_begin_depth, clock, reset, rsp_ch.valid && rsp_ch.kind == KIND_NODE_BEG |-> rsp_ch.depth != 8'd0, "node begin reported at depth zero")
   `DTBP_ASSERT(a_name_nonzero, clock, reset, rsp_ch.valid && rsp_ch.kind == KIND_NAME_CHAR |-> rsp_ch.name_char != 8'd0, "terminator reported as name character")
   `DTBP_ASSERT(a_done_silent, clock, reset, adv && !in_first_ff && phase_ff == PH_DONE |=> !out_valid_ff, "event produced after parsing stopped")
   `DTBP_ASSERT_ALWAYS(a_pos_bound, clock, 32'(pos_ff) <= 32'(BLOB_BYTES), "byte position beyond blob limit")

endmodule
